FILE: hw/rtl/bbpa_pkg.sv
// Shared types and constants for the block pool allocator.
// No dependencies; imported by every module under hw/rtl.
`timescale 1ns / 1ps

package bbpa_pkg;

  // Free map is stored as rows of ROW_W bits, one bit per block.
  localparam int ROW_W    = 32;
  localparam int ROW_BITS = 5;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EXHAUSTED = 2'd1,
    STAT_INVALID   = 2'd2
  } stat_t;

  typedef enum logic [1:0] {
    REG_POOL_BASE   = 2'd0,
    REG_BLOCK_SIZE  = 2'd1,
    REG_BLOCK_COUNT = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_FREE_RD,
    S_FREE_WR,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_MUL,
    S_ADD,
    S_RESP
  } state_t;

  // Free map port controls.
  typedef struct packed {
    logic rd;
    logic wr;
    logic clr;
  } map_ctl_t;

  // Lowest set bit of a row; 0 when the row is empty.
  function automatic logic [ROW_BITS-1:0] first_set(input logic [ROW_W-1:0] row);
    logic [ROW_BITS-1:0] pos;
    pos = '0;
    for (int b = ROW_W - 1; b >= 0; b--) begin
      if (row[b]) begin
        pos = ROW_BITS'(b);
      end
    end
    return pos;
  endfunction

endpackage

FILE: hw/rtl/bbpa_div.sv
// Serial restoring divider: one quotient bit per cycle.
// Depends on bbpa_pkg.
`timescale 1ns / 1ps

module bbpa_div
  import bbpa_pkg::*;
#(
  parameter int ADDR_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [ADDR_WIDTH-1:0] dividend,
  input  logic [15:0]           divisor,
  output logic                  done,
  output logic [ADDR_WIDTH-1:0] quotient
);

  localparam int CNT_W = $clog2(ADDR_WIDTH + 1);

  logic [ADDR_WIDTH-1:0] quo_r, quo_nxt;
  logic [15:0]           rem_r, rem_nxt;
  logic [15:0]           dvs_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  busy_r;
  logic                  done_r;
  logic [16:0]           trial;
  logic                  ge;

  always_comb begin
    trial   = {rem_r, quo_r[ADDR_WIDTH-1]};
    ge      = trial >= {1'b0, dvs_r};
    rem_nxt = ge ? 16'(trial - {1'b0, dvs_r}) : trial[15:0];
    quo_nxt = {quo_r[ADDR_WIDTH-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(ADDR_WIDTH);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: hw/rtl/bbpa_map.sv
// Free map storage: row memory with registered read and per-row valid bits.
// A row not written since reset or clear reads as all free. Depends on bbpa_pkg.
`timescale 1ns / 1ps

module bbpa_map
  import bbpa_pkg::*;
#(
  parameter int ROWS   = 8,
  parameter int ROW_AW = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  map_ctl_t          ctl,
  input  logic [ROW_AW-1:0] row,
  input  logic [ROW_W-1:0]  wdata,
  output logic [ROW_W-1:0]  rdata
);

  logic [ROW_W-1:0] mem [ROWS];
  logic [ROWS-1:0]  row_vld_r;
  logic [ROW_W-1:0] rdata_r;
  logic             rvld_r;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[row] <= wdata;
    end
    if (ctl.rd) begin
      rdata_r <= mem[row];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rvld_r    <= 1'b0;
    end else begin
      if (ctl.clr) begin
        row_vld_r <= '0;
      end else if (ctl.wr) begin
        row_vld_r[row] <= 1'b1;
      end
      if (ctl.rd) begin
        rvld_r <= row_vld_r[row];
      end
    end
  end

  assign rdata = rvld_r ? rdata_r : '1;

endmodule

FILE: hw/rtl/bitmap_block_pool_allocator.sv
// Accepted beat to result valid: allocate scans 32-block rows for a free block, then
// multiplies and adds; exhausted stops past the live rows; free runs the serial divider (one
// quotient bit a cycle), then reads and writes the row, or stops on an invalid pointer;
// clear, null free, zero block size, unused skip to the result. One beat in flight: the next
// beat is taken the cycle after the result loads into the output register. Reset: all blocks
// free via row valid bits, no clearing pass; pool_base 0, block_size 64, block_count 256.
`timescale 1ns / 1ps

module bitmap_block_pool_allocator
  import bbpa_pkg::*;
#(
  parameter int MAX_BLOCKS = 256,
  parameter int ADDR_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_address_out,
  output logic [7:0]  out_block_index,
  output logic [1:0]  out_status
);

  localparam int ROWS   = (MAX_BLOCKS + ROW_W - 1) / ROW_W;
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int FI_W   = ROW_AW + ROW_BITS;
  localparam int N_W    = FI_W + 1;
  localparam int LIM_W  = (N_W > 9) ? N_W : 9;
  localparam int PROD_W = FI_W + 16;
  localparam int SUM_W  = (ADDR_WIDTH > PROD_W) ? ADDR_WIDTH : PROD_W;

  logic [31:0]       pool_base_r;
  logic [15:0]       block_size_r;
  logic [8:0]        block_count_r;

  state_t            state_r, state_nxt;
  logic [ROW_AW:0]   scan_row_r, scan_row_nxt;
  logic [FI_W-1:0]   fi_r, fi_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [31:0]       res_addr_r, res_addr_nxt;
  logic [7:0]        res_idx_r, res_idx_nxt;
  stat_t             res_stat_r, res_stat_nxt;

  logic              out_valid_r;
  logic [31:0]       out_addr_r;
  logic [7:0]        out_idx_r;
  stat_t             out_stat_r;
  logic              out_load;

  logic [LIM_W-1:0]      lim_bc, lim_max;
  logic [N_W-1:0]        n_ext;
  logic [ROW_W-1:0]      lim_mask, masked;
  logic [ROW_BITS-1:0]   pos;
  logic [ADDR_WIDTH-1:0] offset;
  logic [ADDR_WIDTH-1:0] quotient;
  logic                  div_start, div_done;
  logic                  q_in_range;
  logic [SUM_W-1:0]      sum;

  map_ctl_t          map_ctl;
  logic [ROW_AW-1:0] map_row;
  logic [ROW_W-1:0]  map_wdata, map_rdata;

  // Configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r   <= '0;
      block_size_r  <= 16'd64;
      block_count_r <= 9'd256;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_POOL_BASE:   pool_base_r   <= cfg_data;
        REG_BLOCK_SIZE:  block_size_r  <= cfg_data[15:0];
        REG_BLOCK_COUNT: block_count_r <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Live block count, saturated to the pool depth
  always_comb begin
    lim_bc  = LIM_W'(block_count_r);
    lim_max = LIM_W'(MAX_BLOCKS);
    n_ext   = N_W'((lim_bc > lim_max) ? lim_max : lim_bc);
  end

  assign offset     = ADDR_WIDTH'(in_address) - ADDR_WIDTH'(pool_base_r);
  assign q_in_range = quotient < ADDR_WIDTH'(n_ext);

  bbpa_div #(
    .ADDR_WIDTH(ADDR_WIDTH)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(offset),
    .divisor (block_size_r),
    .done    (div_done),
    .quotient(quotient)
  );

  bbpa_map #(
    .ROWS  (ROWS),
    .ROW_AW(ROW_AW)
  ) u_map (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (map_ctl),
    .row  (map_row),
    .wdata(map_wdata),
    .rdata(map_rdata)
  );

  // Blocks past the live count in the last partial row never count as free
  always_comb begin
    if (scan_row_r == n_ext[N_W-1:ROW_BITS]) begin
      lim_mask = (ROW_W'(1) << n_ext[ROW_BITS-1:0]) - ROW_W'(1);
    end else begin
      lim_mask = '1;
    end
    masked = map_rdata & lim_mask;
    pos    = first_set(masked);
    sum    = SUM_W'(ADDR_WIDTH'(pool_base_r)) + SUM_W'(prod_r);
  end

  always_comb begin
    state_nxt    = state_r;
    scan_row_nxt = scan_row_r;
    fi_nxt       = fi_r;
    prod_nxt     = prod_r;
    res_addr_nxt = res_addr_r;
    res_idx_nxt  = res_idx_r;
    res_stat_nxt = res_stat_r;
    map_ctl      = '0;
    map_row      = scan_row_r[ROW_AW-1:0];
    map_wdata    = map_rdata & ~(ROW_W'(1) << pos);
    div_start    = 1'b0;
    out_load     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_addr_nxt = '0;
          res_idx_nxt  = '0;
          res_stat_nxt = STAT_OK;
          state_nxt    = S_RESP;
          unique case (in_operation)
            OP_ALLOC: begin
              scan_row_nxt = '0;
              state_nxt    = S_SCAN_RD;
            end
            OP_FREE: begin
              if (in_address == '0) begin
                state_nxt = S_RESP;
              end else if (block_size_r == '0) begin
                res_stat_nxt = STAT_INVALID;
              end else begin
                div_start = 1'b1;
                state_nxt = S_DIV;
              end
            end
            OP_CLEAR: begin
              map_ctl.clr = 1'b1;
            end
            default: ;
          endcase
        end
      end

      S_DIV: begin
        if (div_done) begin
          if (q_in_range) begin
            fi_nxt    = quotient[FI_W-1:0];
            state_nxt = S_FREE_RD;
          end else begin
            res_stat_nxt = STAT_INVALID;
            state_nxt    = S_RESP;
          end
        end
      end

      S_FREE_RD: begin
        map_ctl.rd = 1'b1;
        map_row    = fi_r[FI_W-1:ROW_BITS];
        state_nxt  = S_FREE_WR;
      end

      S_FREE_WR: begin
        map_ctl.wr  = 1'b1;
        map_row     = fi_r[FI_W-1:ROW_BITS];
        map_wdata   = map_rdata | (ROW_W'(1) << fi_r[ROW_BITS-1:0]);
        res_idx_nxt = 8'(fi_r);
        state_nxt   = S_RESP;
      end

      S_SCAN_RD: begin
        // Stop once the row starts at or past the live count
        if ({scan_row_r, {ROW_BITS{1'b0}}} >= n_ext) begin
          res_stat_nxt = STAT_EXHAUSTED;
          state_nxt    = S_RESP;
        end else begin
          map_ctl.rd = 1'b1;
          state_nxt  = S_SCAN_CHK;
        end
      end

      S_SCAN_CHK: begin
        if (|masked) begin
          map_ctl.wr = 1'b1;
          fi_nxt     = {scan_row_r[ROW_AW-1:0], pos};
          state_nxt  = S_MUL;
        end else begin
          scan_row_nxt = scan_row_r + 1'b1;
          state_nxt    = S_SCAN_RD;
        end
      end

      S_MUL: begin
        prod_nxt  = PROD_W'(fi_r) * PROD_W'(block_size_r);
        state_nxt = S_ADD;
      end

      S_ADD: begin
        res_addr_nxt = 32'(sum[ADDR_WIDTH-1:0]);
        res_idx_nxt  = 8'(fi_r);
        state_nxt    = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_row_r <= scan_row_nxt;
    fi_r       <= fi_nxt;
    prod_r     <= prod_nxt;
    res_addr_r <= res_addr_nxt;
    res_idx_r  <= res_idx_nxt;
    res_stat_r <= res_stat_nxt;
    if (out_load) begin
      out_addr_r <= res_addr_r;
      out_idx_r  <= res_idx_r;
      out_stat_r <= res_stat_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_address_out = out_addr_r;
  assign out_block_index = out_idx_r;
  assign out_status      = out_stat_r;

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stat_r != STAT_OK |-> out_addr_r == '0 && out_idx_r == '0)
    else $error("failed request carries a nonzero address or index");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside the divide state");

  a_map_wr_state: assert property (@(posedge clk) disable iff (!rst_n)
    map_ctl.wr |-> state_r == S_SCAN_CHK || state_r == S_FREE_WR)
    else $error("free map written outside an update state");

  a_map_ctl_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({map_ctl.rd, map_ctl.wr, map_ctl.clr}))
    else $error("free map read, write and clear overlap");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r != S_IDLE)
    else $error("accepted beat did not start work");

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the bitmap block pool allocator: directed table, then random phases.
// Depends on hw/rtl/bbpa_pkg.sv and hw/rtl/bitmap_block_pool_allocator.sv.
`timescale 1ns / 1ps

module tb;
  import bbpa_pkg::*;

  localparam int          POOL_BLOCKS  = 256;
  localparam int          ADDR_BITS    = 32;
  localparam int unsigned CYCLE_LIMIT  = 1_200_000;
  localparam int          RAND_PHASES  = 16;
  localparam int          PHASE_ITEMS  = 106;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          HOLD_AFTER   = 800;
  localparam int          DRAIN_CYCLES = 64;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam logic [1:0]  REG_UNUSED   = 2'd3;

  typedef struct packed {
    logic [31:0] addr;
    logic [7:0]  idx;
    stat_t       status;
  } pool_result_t;

  typedef struct {
    bit           is_write;
    logic [1:0]   code;
    logic [31:0]  data;
    bit           fixed;
    pool_result_t res;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_operation;
  logic [31:0] in_address;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_address_out;
  logic [7:0]  out_block_index;
  logic [1:0]  out_status;

  // Shadow of the allocator: registers and free map.
  logic [31:0]            pool_base_q;
  logic [15:0]            block_size_q;
  logic [8:0]             block_count_q;
  logic [POOL_BLOCKS-1:0] free_bits;

  pool_result_t pending_results[$];
  stim_row_t    stim_rows[$];
  int unsigned  errors = 0;
  int unsigned  items_sent;
  int unsigned  results_seen = 0;
  int unsigned  cycles = 0;

  bitmap_block_pool_allocator #(
    .MAX_BLOCKS(POOL_BLOCKS),
    .ADDR_WIDTH(ADDR_BITS)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_operation(in_operation),
    .in_address(in_address),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_address_out(out_address_out),
    .out_block_index(out_block_index),
    .out_status(out_status)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int unsigned live_blocks();
    return (block_count_q > POOL_BLOCKS) ? POOL_BLOCKS : int'(block_count_q);
  endfunction

  // Compute the response to one request and update the shadow free map.
  function automatic pool_result_t predict_pool_op(logic [1:0] op, logic [31:0] addr);
    pool_result_t     r;
    int unsigned      n;
    bit               found;
    logic [31:0]      offset;
    longint unsigned  quot;
    r        = '0;
    r.status = STAT_OK;
    n        = live_blocks();
    found    = 1'b0;
    case (op)
      OP_ALLOC: begin
        for (int i = 0; i < POOL_BLOCKS; i++) begin
          if (!found && i < n && free_bits[i]) begin
            free_bits[i] = 1'b0;
            r.addr       = pool_base_q + 32'(i) * {16'h0, block_size_q};
            r.idx        = 8'(i);
            found        = 1'b1;
          end
        end
        if (!found) r.status = STAT_EXHAUSTED;
      end
      OP_FREE: begin
        if (addr != 32'h0) begin
          offset = addr - pool_base_q;
          if (block_size_q == 16'h0) quot = '1;
          else quot = {32'h0, offset} / {48'h0, block_size_q};
          if (quot < n) begin
            free_bits[quot[7:0]] = 1'b1;
            r.idx                = quot[7:0];
          end else begin
            r.status = STAT_INVALID;
          end
        end
      end
      OP_CLEAR: free_bits = '1;
      default: ;
    endcase
    return r;
  endfunction

  function automatic int unsigned pick_gap(input bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void add_write(logic [1:0] code, logic [31:0] data);
    stim_row_t row;
    row.is_write = 1'b1;
    row.code     = code;
    row.data     = data;
    row.fixed    = 1'b0;
    row.res      = '0;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_item(logic [1:0] op, logic [31:0] addr, bit fixed,
                                   logic [31:0] ea, logic [7:0] ei, stat_t es);
    stim_row_t row;
    row.is_write   = 1'b0;
    row.code       = op;
    row.data       = addr;
    row.fixed      = fixed;
    row.res.addr   = ea;
    row.res.idx    = ei;
    row.res.status = es;
    stim_rows.push_back(row);
  endfunction

  task automatic wait_idle();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] code, logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= code;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (code)
      REG_POOL_BASE:   pool_base_q   = data;
      REG_BLOCK_SIZE:  block_size_q  = data[15:0];
      REG_BLOCK_COUNT: block_count_q = data[8:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Offer one request beat; valid stays high into the next beat when no gap is drawn.
  task automatic send_item(logic [1:0] op, logic [31:0] addr, bit fixed, pool_result_t res);
    pool_result_t r;
    int unsigned  g;
    @(negedge clk);
    in_valid     <= 1'b1;
    in_operation <= op;
    in_address   <= addr;
    do @(posedge clk); while (!in_ready);
    r = predict_pool_op(op, addr);
    pending_results.push_back(fixed ? res : r);
    items_sent++;
    g = pick_gap((items_sent % 200) < 40);
    if (g > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  task automatic end_input();
    if (in_valid) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  always @(posedge clk) begin
    pool_result_t e;
    if (rst_n && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (pending_results.size() == 0) begin
        $error("result beat with no request outstanding");
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_address_out !== e.addr) begin
          $error("address_out: expected %h, got %h", e.addr, out_address_out);
          errors++;
        end
        if (out_block_index !== e.idx) begin
          $error("block_index: expected %0d, got %0d", e.idx, out_block_index);
          errors++;
        end
        if (out_status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_status);
          errors++;
        end
      end
    end
  end

  // Result side: random stalls, plus one long hold-off so the block backs up.
  initial begin
    int unsigned g;
    bit          hold_done;
    out_ready = 1'b0;
    hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        g = pick_gap((results_seen % 256) < 48);
        out_ready <= (g == 0);
        if (g > 1) repeat (g - 1) @(negedge clk);
      end
    end
  end

  initial begin
    stim_row_t   row;
    logic [31:0] cb;
    logic [15:0] cs;
    logic [8:0]  cc;
    logic [1:0]  op;
    logic [31:0] addr;
    int unsigned n;
    int unsigned idx;
    int unsigned r;

    rst_n         = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    in_operation  = '0;
    in_address    = '0;
    items_sent    = 0;
    pool_base_q   = 32'h0;
    block_size_q  = 16'd64;
    block_count_q = 9'd256;
    free_bits     = '1;

    // Reset settings: base 0, 64-byte blocks, 256 blocks.
    add_item(OP_FREE,   32'h0,        1, 32'h0,  8'd0,   STAT_OK);
    add_item(OP_ALLOC,  32'h0,        1, 32'h0,  8'd0,   STAT_OK);
    add_item(OP_ALLOC,  32'hFFFFFFFF, 1, 32'd64, 8'd1,   STAT_OK);
    add_item(OP_UNUSED, 32'hFFFFFFFF, 1, 32'h0,  8'd0,   STAT_OK);
    add_item(OP_FREE,   32'd64,       1, 32'h0,  8'd1,   STAT_OK);
    add_item(OP_FREE,   32'd64,       1, 32'h0,  8'd1,   STAT_OK);
    add_item(OP_FREE,   32'hFFFFFFFF, 1, 32'h0,  8'd0,   STAT_INVALID);
    add_item(OP_FREE,   32'd16383,    1, 32'h0,  8'd255, STAT_OK);
    add_item(OP_FREE,   32'd16384,    1, 32'h0,  8'd0,   STAT_INVALID);
    add_item(OP_CLEAR,  32'h0,        1, 32'h0,  8'd0,   STAT_OK);
    // One block at the top of the address space, largest block size.
    add_write(REG_BLOCK_COUNT, 32'd1);
    add_write(REG_POOL_BASE,   32'hFFFFFFFF);
    add_write(REG_BLOCK_SIZE,  32'h0000FFFF);
    add_item(OP_ALLOC,  32'h0,        1, 32'hFFFFFFFF, 8'd0, STAT_OK);
    add_item(OP_ALLOC,  32'h0,        1, 32'h0,        8'd0, STAT_EXHAUSTED);
    add_item(OP_FREE,   32'hFFFFFFFF, 1, 32'h0,        8'd0, STAT_OK);
    add_item(OP_FREE,   32'h0,        1, 32'h0,        8'd0, STAT_OK);
    add_item(OP_FREE,   32'h0000FFFE, 0, 32'h0,        8'd0, STAT_OK);
    // Zero block size, count above the pool size.
    add_write(REG_BLOCK_SIZE,  32'h0);
    add_write(REG_BLOCK_COUNT, 32'h1FF);
    add_write(REG_POOL_BASE,   32'h1000);
    add_item(OP_ALLOC,  32'h0,        1, 32'h1000, 8'd0, STAT_OK);
    add_item(OP_ALLOC,  32'h0,        1, 32'h1000, 8'd1, STAT_OK);
    add_item(OP_FREE,   32'h1000,     1, 32'h0,    8'd0, STAT_INVALID);
    // Empty pool.
    add_write(REG_BLOCK_COUNT, 32'h0);
    add_write(REG_UNUSED,      32'hA5A5A5A5);
    add_item(OP_ALLOC,  32'h0,        1, 32'h0, 8'd0, STAT_EXHAUSTED);
    add_item(OP_FREE,   32'h1000,     1, 32'h0, 8'd0, STAT_INVALID);
    // Byte-sized blocks from address 0.
    add_write(REG_BLOCK_SIZE,  32'd1);
    add_write(REG_BLOCK_COUNT, 32'd256);
    add_write(REG_POOL_BASE,   32'h0);
    add_item(OP_CLEAR,  32'h0,        1, 32'h0, 8'd0,   STAT_OK);
    add_item(OP_ALLOC,  32'h0,        1, 32'h0, 8'd0,   STAT_OK);
    add_item(OP_FREE,   32'd255,      1, 32'h0, 8'd255, STAT_OK);
    add_item(OP_FREE,   32'd256,      1, 32'h0, 8'd0,   STAT_INVALID);
    add_item(OP_ALLOC,  32'h0,        1, 32'h1, 8'd1,   STAT_OK);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (stim_rows[k]) begin
      row = stim_rows[k];
      if (row.is_write) begin
        end_input();
        wait_idle();
        write_reg(row.code, row.data);
      end else begin
        send_item(row.code, row.data, row.fixed, row.res);
      end
    end

    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      end_input();
      wait_idle();
      case (phase)
        0: begin cb = 32'h0;        cs = 16'd1;     cc = 9'd256; end
        1: begin cb = 32'hFFFFFFFF; cs = 16'hFFFF;  cc = 9'd256; end
        2: begin cb = $urandom;     cs = 16'h0;     cc = 9'($urandom_range(1, 16)); end
        3: begin cb = $urandom;     cs = 16'($urandom_range(1, 255)); cc = 9'd0; end
        4: begin cb = $urandom;     cs = 16'($urandom_range(1, 64));
                 cc = 9'($urandom_range(257, 511)); end
        5: begin cb = 32'h0;        cs = 16'hFFFF;  cc = 9'd1; end
        default: begin
          r = $urandom_range(0, 7);
          cb = (r < 2) ? 32'h0 : (r == 2) ? 32'hFFFFFFFF : $urandom;
          r = $urandom_range(0, 9);
          cs = (r == 0) ? 16'h0 : (r == 1) ? 16'hFFFF : 16'($urandom_range(1, 300));
          r = $urandom_range(0, 5);
          cc = (r < 4) ? 9'($urandom_range(1, 40)) :
               (r == 4) ? 9'd256 : 9'($urandom_range(0, 511));
        end
      endcase
      write_reg(REG_POOL_BASE, cb);
      // Junk above the register width must be dropped.
      write_reg(REG_BLOCK_SIZE, {(phase > 5 && $urandom_range(0, 1)) ? 16'($urandom) : 16'h0,
                                 cs});
      write_reg(REG_BLOCK_COUNT, {(phase > 5 && $urandom_range(0, 1)) ? 23'($urandom) : 23'h0,
                                  cc});
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, $urandom);

      n = live_blocks();
      repeat (PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 52) begin
          op   = OP_ALLOC;
          addr = $urandom;
        end else if (r < 94) begin
          op = OP_FREE;
          r  = $urandom_range(0, 9);
          if (r < 7) begin
            // Aim inside a block, one past the end now and then.
            idx  = $urandom_range(0, n);
            addr = cb + 32'(idx) * {16'h0, cs} +
                   ((cs != 16'h0) ? 32'($urandom_range(0, cs - 1)) : 32'h0);
          end else if (r < 8) begin
            addr = 32'h0;
          end else begin
            addr = $urandom;
          end
        end else if (r < 97) begin
          op   = OP_CLEAR;
          addr = $urandom;
        end else begin
          op   = OP_UNUSED;
          addr = $urandom;
        end
        send_item(op, addr, 1'b0, '0);
      end
    end

    end_input();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/bbpa_pkg.sv
hw/rtl/bbpa_div.sv
hw/rtl/bbpa_map.sv
hw/rtl/bitmap_block_pool_allocator.sv
sim/tb.sv
